FILE: sv/ati_pkg.sv
package ati_pkg;

    localparam int SEGMENTS_DEF = 12;
    localparam int ROM_LAST     = 12;
    localparam int STEP_DM      = 5000;
    localparam int HALF_STEP    = 2500;

    localparam int ALT_W  = 19;
    localparam int SPD_W  = 17;
    localparam int TEMP_W = 15;
    localparam int PRES_W = 17;
    localparam int DENS_W = 14;
    localparam int SND_W  = 16;
    localparam int MACH_W = 18;

    localparam int MAG_W  = ALT_W - 1;
    localparam int RAW_W  = 6;
    localparam int ROW_W  = 4;
    localparam int OFF_W  = 13;
    localparam int VAL_W  = 17;
    localparam int DY_W   = 14;
    localparam int SCL_W  = 29;
    localparam int NUM_W  = 30;
    localparam int LRP_W  = 32;

    // floor(x / 5000) as (x * SEG_RECIP) >> SEG_SHIFT, exact for x below 2^18
    localparam int SEGP_W = 2 * MAG_W;
    localparam logic [MAG_W-1:0] SEG_RECIP = 18'd214749;
    localparam int SEG_SHIFT = 30;

    // floor(x / 5000) as (x * RND_RECIP) >> RND_SHIFT, exact for x below 2^29
    localparam int RNDP_W = SCL_W + 30;
    localparam logic [29:0] RND_RECIP = 30'd879609303;
    localparam int RND_SHIFT = 42;

    typedef struct packed {
        logic [VAL_W-1:0] temp;
        logic [VAL_W-1:0] pres;
        logic [VAL_W-1:0] dens;
        logic [VAL_W-1:0] snd;
    } ati_vals_t;

    typedef struct packed {
        logic signed [DY_W-1:0] temp;
        logic signed [DY_W-1:0] pres;
        logic signed [DY_W-1:0] dens;
        logic signed [DY_W-1:0] snd;
    } ati_dy_t;

    typedef struct packed {
        logic [SCL_W-1:0] temp;
        logic [SCL_W-1:0] pres;
        logic [SCL_W-1:0] dens;
        logic [SCL_W-1:0] snd;
    } ati_scl_t;

    typedef struct packed {
        logic [TEMP_W-1:0] temp;
        logic [PRES_W-1:0] pres;
        logic [DENS_W-1:0] dens;
        logic [SND_W-1:0]  snd;
    } ati_res_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [OFF_W-1:0] off;
        logic [SPD_W-1:0] speed;
    } ati_seg_t;

    typedef struct packed {
        ati_res_t          res;
        logic [SCL_W-1:0]  divisor;
        logic [SCL_W-1:0]  rem;
        logic [MACH_W-1:0] low;
        logic              sat;
    } ati_dvin_t;

    function automatic ati_vals_t rom_row(input logic [ROW_W-1:0] idx);
        ati_vals_t v;
        unique case (idx)
            4'd0:    v = {17'd28815, 17'd101325, 17'd12250, 17'd34029};
            4'd1:    v = {17'd28490, 17'd95463,  17'd11673, 17'd33837};
            4'd2:    v = {17'd28165, 17'd89976,  17'd11117, 17'd33644};
            4'd3:    v = {17'd27840, 17'd84808,  17'd10581, 17'd33450};
            4'd4:    v = {17'd27515, 17'd79916,  17'd10066, 17'd33254};
            4'd5:    v = {17'd27190, 17'd75260,  17'd9570,  17'd33057};
            4'd6:    v = {17'd26865, 17'd70801,  17'd9093,  17'd32858};
            4'd7:    v = {17'd26540, 17'd66604,  17'd8635,  17'd32658};
            4'd8:    v = {17'd26215, 17'd62634,  17'd8196,  17'd32456};
            4'd9:    v = {17'd25890, 17'd58860,  17'd7775,  17'd32252};
            4'd10:   v = {17'd25565, 17'd55252,  17'd7369,  17'd32047};
            4'd11:   v = {17'd25240, 17'd51881,  17'd6979,  17'd31840};
            default: v = {17'd24915, 17'd48720,  17'd6605,  17'd31631};
        endcase
        return v;
    endfunction

endpackage

FILE: sv/ati_front.sv
module ati_front #(
    parameter int SEGMENTS = ati_pkg::SEGMENTS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [ati_pkg::ALT_W-1:0] altitude,
    input  logic [ati_pkg::SPD_W-1:0] speed,
    output logic                      out_valid,
    input  logic                      out_ready,
    output ati_pkg::ati_seg_t         seg
);

    localparam int TOP_ROW = (SEGMENTS > ati_pkg::ROM_LAST) ? ati_pkg::ROM_LAST :
                             ((SEGMENTS < 1) ? 1 : SEGMENTS);
    localparam logic [ati_pkg::MAG_W-1:0] HI_DM =
        ati_pkg::MAG_W'(TOP_ROW * ati_pkg::STEP_DM);

    logic                        s1_valid_reg;
    logic                        s1_le0_reg;
    logic                        s1_hi_reg;
    logic [ati_pkg::MAG_W-1:0]   s1_mag_reg;
    logic [ati_pkg::RAW_W-1:0]   s1_raw_reg;
    logic [ati_pkg::SPD_W-1:0]   s1_speed_reg;

    logic                        s1_le0_next;
    logic                        s1_hi_next;
    logic [ati_pkg::MAG_W-1:0]   s1_mag_next;
    logic [ati_pkg::RAW_W-1:0]   s1_raw_next;
    logic [ati_pkg::SEGP_W-1:0]  seg_prod;

    logic                        s2_valid_reg;
    ati_pkg::ati_seg_t           s2_seg_reg;
    ati_pkg::ati_seg_t           s2_seg_next;
    logic [ati_pkg::MAG_W-1:0]   seg_base;
    logic [ati_pkg::MAG_W-1:0]   seg_rest;

    logic en1;
    logic en2;

    assign en2      = !s2_valid_reg || out_ready;
    assign en1      = !s1_valid_reg || en2;
    assign in_ready = en1;

    // segment index by reciprocal multiply
    always_comb
    begin
        s1_mag_next = altitude[ati_pkg::MAG_W-1:0];
        s1_le0_next = altitude[ati_pkg::ALT_W-1] || (altitude == '0);
        s1_hi_next  = !altitude[ati_pkg::ALT_W-1] && (s1_mag_next >= HI_DM);
        seg_prod    = ati_pkg::SEGP_W'(s1_mag_next) * ati_pkg::SEGP_W'(ati_pkg::SEG_RECIP);
        s1_raw_next = seg_prod[ati_pkg::SEG_SHIFT +: ati_pkg::RAW_W];
    end

    // offset into the segment, clamp at both ends of the table
    always_comb
    begin
        seg_base = ati_pkg::MAG_W'(ati_pkg::MAG_W'(s1_raw_reg) *
                                   ati_pkg::MAG_W'(ati_pkg::STEP_DM));
        seg_rest = s1_mag_reg - seg_base;
        s2_seg_next.speed = s1_speed_reg;
        priority if (s1_le0_reg)
        begin
            s2_seg_next.row = '0;
            s2_seg_next.off = '0;
        end
        else if (s1_hi_reg)
        begin
            s2_seg_next.row = ati_pkg::ROW_W'(TOP_ROW);
            s2_seg_next.off = '0;
        end
        else
        begin
            s2_seg_next.row = s1_raw_reg[ati_pkg::ROW_W-1:0];
            s2_seg_next.off = seg_rest[ati_pkg::OFF_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_le0_reg   <= s1_le0_next;
            s1_hi_reg    <= s1_hi_next;
            s1_mag_reg   <= s1_mag_next;
            s1_raw_reg   <= s1_raw_next;
            s1_speed_reg <= speed;
        end
        if (en2)
        begin
            s2_seg_reg <= s2_seg_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign seg       = s2_seg_reg;

endmodule

FILE: sv/ati_interp.sv
module ati_interp (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ati_pkg::ati_seg_t  seg,
    output logic               out_valid,
    input  logic               out_ready,
    output ati_pkg::ati_dvin_t dv
);

    function automatic logic signed [ati_pkg::DY_W-1:0] slope_of(
        input logic [ati_pkg::VAL_W-1:0] y1,
        input logic [ati_pkg::VAL_W-1:0] y0
    );
        logic signed [ati_pkg::VAL_W:0] d;
        d = $signed({1'b0, y1}) - $signed({1'b0, y0});
        return d[ati_pkg::DY_W-1:0];
    endfunction

    function automatic logic [ati_pkg::SCL_W-1:0] lerp(
        input logic [ati_pkg::VAL_W-1:0]        y0,
        input logic signed [ati_pkg::DY_W-1:0]  dy,
        input logic [ati_pkg::OFF_W-1:0]        off
    );
        logic signed [ati_pkg::LRP_W-1:0] base;
        logic signed [ati_pkg::LRP_W-1:0] slope;
        logic signed [ati_pkg::LRP_W-1:0] sum;
        base  = $signed(ati_pkg::LRP_W'(y0)) * $signed(ati_pkg::LRP_W'(ati_pkg::STEP_DM));
        slope = ati_pkg::LRP_W'(dy) * $signed(ati_pkg::LRP_W'(off));
        sum   = base + slope;
        return sum[ati_pkg::SCL_W-1:0];
    endfunction

    // add half a step, divide by the step
    function automatic logic [ati_pkg::VAL_W-1:0] round_seg(
        input logic [ati_pkg::SCL_W-1:0] v
    );
        logic [ati_pkg::RNDP_W-1:0] prod;
        prod = ati_pkg::RNDP_W'(v + ati_pkg::SCL_W'(ati_pkg::HALF_STEP)) *
               ati_pkg::RNDP_W'(ati_pkg::RND_RECIP);
        return prod[ati_pkg::RND_SHIFT +: ati_pkg::VAL_W];
    endfunction

    logic                        s3_valid_reg;
    ati_pkg::ati_vals_t          s3_y0_reg;
    ati_pkg::ati_dy_t            s3_dy_reg;
    logic [ati_pkg::OFF_W-1:0]   s3_off_reg;
    logic [ati_pkg::NUM_W-1:0]   s3_num_reg;
    ati_pkg::ati_vals_t          s3_y0_next;
    ati_pkg::ati_vals_t          y1;
    ati_pkg::ati_dy_t            s3_dy_next;
    logic [ati_pkg::NUM_W-1:0]   s3_num_next;
    logic [ati_pkg::ROW_W-1:0]   row_up;

    logic                        s4_valid_reg;
    ati_pkg::ati_scl_t           s4_scl_reg;
    logic [ati_pkg::NUM_W-1:0]   s4_num_reg;
    ati_pkg::ati_scl_t           s4_scl_next;

    logic                        s5_valid_reg;
    ati_pkg::ati_dvin_t          s5_dv_reg;
    ati_pkg::ati_dvin_t          s5_dv_next;

    logic en3;
    logic en4;
    logic en5;

    assign en5      = !s5_valid_reg || out_ready;
    assign en4      = !s4_valid_reg || en5;
    assign en3      = !s3_valid_reg || en4;
    assign in_ready = en3;

    always_comb
    begin
        row_up = (seg.row >= ati_pkg::ROW_W'(ati_pkg::ROM_LAST)) ?
                 ati_pkg::ROW_W'(ati_pkg::ROM_LAST) : seg.row + ati_pkg::ROW_W'(1);
        s3_y0_next      = ati_pkg::rom_row(seg.row);
        y1              = ati_pkg::rom_row(row_up);
        s3_dy_next.temp = slope_of(y1.temp, s3_y0_next.temp);
        s3_dy_next.pres = slope_of(y1.pres, s3_y0_next.pres);
        s3_dy_next.dens = slope_of(y1.dens, s3_y0_next.dens);
        s3_dy_next.snd  = slope_of(y1.snd,  s3_y0_next.snd);
        s3_num_next     = ati_pkg::NUM_W'(seg.speed) * ati_pkg::NUM_W'(ati_pkg::STEP_DM);
    end

    always_comb
    begin
        s4_scl_next.temp = lerp(s3_y0_reg.temp, s3_dy_reg.temp, s3_off_reg);
        s4_scl_next.pres = lerp(s3_y0_reg.pres, s3_dy_reg.pres, s3_off_reg);
        s4_scl_next.dens = lerp(s3_y0_reg.dens, s3_dy_reg.dens, s3_off_reg);
        s4_scl_next.snd  = lerp(s3_y0_reg.snd,  s3_dy_reg.snd,  s3_off_reg);
    end

    // quotient overflows 18 bits when speed*5000*2^16 >= scaled sound speed * 2^18
    always_comb
    begin
        s5_dv_next.res.temp = ati_pkg::TEMP_W'(round_seg(s4_scl_reg.temp));
        s5_dv_next.res.pres = ati_pkg::PRES_W'(round_seg(s4_scl_reg.pres));
        s5_dv_next.res.dens = ati_pkg::DENS_W'(round_seg(s4_scl_reg.dens));
        s5_dv_next.res.snd  = ati_pkg::SND_W'(round_seg(s4_scl_reg.snd));
        s5_dv_next.divisor  = s4_scl_reg.snd;
        s5_dv_next.sat      = s4_num_reg >= {s4_scl_reg.snd, 2'b00};
        s5_dv_next.rem      = ati_pkg::SCL_W'(s4_num_reg[ati_pkg::NUM_W-1:2]);
        s5_dv_next.low      = {s4_num_reg[1:0], {(ati_pkg::MACH_W - 2){1'b0}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (en3)
            begin
                s3_valid_reg <= in_valid;
            end
            if (en4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (en5)
            begin
                s5_valid_reg <= s4_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_y0_reg  <= s3_y0_next;
            s3_dy_reg  <= s3_dy_next;
            s3_off_reg <= seg.off;
            s3_num_reg <= s3_num_next;
        end
        if (en4)
        begin
            s4_scl_reg <= s4_scl_next;
            s4_num_reg <= s3_num_reg;
        end
        if (en5)
        begin
            s5_dv_reg <= s5_dv_next;
        end
    end

    assign out_valid = s5_valid_reg;
    assign dv        = s5_dv_reg;

endmodule

FILE: sv/ati_div.sv
module ati_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  ati_pkg::ati_dvin_t         dv,
    output logic                       out_valid,
    input  logic                       out_ready,
    output ati_pkg::ati_res_t          res,
    output logic [ati_pkg::MACH_W-1:0] mach
);

    localparam int NST = ati_pkg::MACH_W;

    logic [NST-1:0]              vld_reg;
    logic [NST-1:0]              sat_reg;
    ati_pkg::ati_res_t           res_reg [NST];
    logic [ati_pkg::SCL_W-1:0]   div_reg [NST];
    logic [ati_pkg::SCL_W-1:0]   rem_reg [NST];
    logic [ati_pkg::MACH_W-1:0]  low_reg [NST];
    logic [ati_pkg::MACH_W-1:0]  quo_reg [NST];

    logic [NST-1:0]              cur_vld;
    logic [NST-1:0]              cur_sat;
    ati_pkg::ati_res_t           cur_res [NST];
    logic [ati_pkg::SCL_W-1:0]   cur_div [NST];
    logic [ati_pkg::SCL_W-1:0]   cur_rem [NST];
    logic [ati_pkg::MACH_W-1:0]  cur_low [NST];
    logic [ati_pkg::MACH_W-1:0]  cur_quo [NST];

    logic [ati_pkg::SCL_W-1:0]   trial   [NST];
    logic [NST-1:0]              take;
    logic [ati_pkg::SCL_W-1:0]   rem_next [NST];
    logic [ati_pkg::MACH_W-1:0]  low_next [NST];
    logic [ati_pkg::MACH_W-1:0]  quo_next [NST];

    logic [NST:0]                en;

    assign en[NST]  = out_ready;
    assign in_ready = en[0];

    for (genvar k = 0; k < NST; k++)
    begin : g_stage
        assign en[k] = !vld_reg[k] || en[k+1];
        if (k == 0)
        begin : g_head
            assign cur_vld[k] = in_valid;
            assign cur_sat[k] = dv.sat;
            assign cur_res[k] = dv.res;
            assign cur_div[k] = dv.divisor;
            assign cur_rem[k] = dv.rem;
            assign cur_low[k] = dv.low;
            assign cur_quo[k] = '0;
        end
        else
        begin : g_body
            assign cur_vld[k] = vld_reg[k-1];
            assign cur_sat[k] = sat_reg[k-1];
            assign cur_res[k] = res_reg[k-1];
            assign cur_div[k] = div_reg[k-1];
            assign cur_rem[k] = rem_reg[k-1];
            assign cur_low[k] = low_reg[k-1];
            assign cur_quo[k] = quo_reg[k-1];
        end
    end

    // one quotient bit per stage: shift in the next numerator bit, subtract if it fits
    always_comb
    begin
        for (int k = 0; k < NST; k++)
        begin
            trial[k]    = {cur_rem[k][ati_pkg::SCL_W-2:0], cur_low[k][ati_pkg::MACH_W-1]};
            take[k]     = trial[k] >= cur_div[k];
            rem_next[k] = take[k] ? (trial[k] - cur_div[k]) : trial[k];
            low_next[k] = {cur_low[k][ati_pkg::MACH_W-2:0], 1'b0};
            quo_next[k] = {cur_quo[k][ati_pkg::MACH_W-2:0], take[k]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NST; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= cur_vld[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NST; k++)
        begin
            if (en[k])
            begin
                sat_reg[k] <= cur_sat[k];
                res_reg[k] <= cur_res[k];
                div_reg[k] <= cur_div[k];
                rem_reg[k] <= rem_next[k];
                low_reg[k] <= low_next[k];
                quo_reg[k] <= quo_next[k];
            end
        end
    end

    assign out_valid = vld_reg[NST-1];
    assign res       = res_reg[NST-1];
    assign mach      = sat_reg[NST-1] ? '1 : quo_reg[NST-1];

endmodule

FILE: sv/atmosphere_table_interpolator.sv
// Channel   Direction  Handshake             Word
// in        input      in_valid / in_ready   altitude_dm, speed_cms
// out       output     out_valid / out_ready temperature_ck, pressure_pa, density_e4,
//                                            sound_speed_cms, mach_q16
//
// One word per cycle sustained while out_ready stays high; a word passes through
// segment lookup (s1, s2), then table read, interpolation and rounding (s3, s4,
// s5), then the Mach divider, which retires one quotient bit per stage.
// Reset clears only the stage valid bits; data registers are not reset.
// A stage holds while the one after it is full and stalled, so empty stages
// keep filling and in_ready drops only when every stage holds a word.
module atmosphere_table_interpolator #(
    parameter int SEGMENTS = ati_pkg::SEGMENTS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [ati_pkg::ALT_W-1:0]  altitude_dm,
    input  logic [ati_pkg::SPD_W-1:0]  speed_cms,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [ati_pkg::TEMP_W-1:0] temperature_ck,
    output logic [ati_pkg::PRES_W-1:0] pressure_pa,
    output logic [ati_pkg::DENS_W-1:0] density_e4,
    output logic [ati_pkg::SND_W-1:0]  sound_speed_cms,
    output logic [ati_pkg::MACH_W-1:0] mach_q16
);

    logic               seg_valid;
    logic               seg_ready;
    ati_pkg::ati_seg_t  seg;
    logic               dv_valid;
    logic               dv_ready;
    ati_pkg::ati_dvin_t dv;
    ati_pkg::ati_res_t  res;

    ati_front #(
        .SEGMENTS (SEGMENTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .altitude  (altitude_dm),
        .speed     (speed_cms),
        .out_valid (seg_valid),
        .out_ready (seg_ready),
        .seg       (seg)
    );

    ati_interp u_interp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (seg_valid),
        .in_ready  (seg_ready),
        .seg       (seg),
        .out_valid (dv_valid),
        .out_ready (dv_ready),
        .dv        (dv)
    );

    ati_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dv_valid),
        .in_ready  (dv_ready),
        .dv        (dv),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res),
        .mach      (mach_q16)
    );

    assign temperature_ck  = res.temp;
    assign pressure_pa     = res.pres;
    assign density_e4      = res.dens;
    assign sound_speed_cms = res.snd;

endmodule

FILE: sv/ati_checker.sv
module ati_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic [ati_pkg::ALT_W-1:0]  altitude_dm,
    input logic [ati_pkg::SPD_W-1:0]  speed_cms,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [ati_pkg::TEMP_W-1:0] temperature_ck,
    input logic [ati_pkg::PRES_W-1:0] pressure_pa,
    input logic [ati_pkg::DENS_W-1:0] density_e4,
    input logic [ati_pkg::SND_W-1:0]  sound_speed_cms,
    input logic [ati_pkg::MACH_W-1:0] mach_q16
);

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(altitude_dm) && $stable(speed_cms))
        else $error("input word changed while waiting");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(mach_q16) && $stable(pressure_pa)
                                    && $stable(temperature_ck))
        else $error("output word changed while stalled");

    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input refused with an empty output stage");

    a_table_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (temperature_ck >= 15'd24915) && (temperature_ck <= 15'd28815)
                   && (sound_speed_cms >= 16'd31631) && (sound_speed_cms <= 16'd34029)
                   && (density_e4 >= 14'd6605) && (density_e4 <= 14'd12250))
        else $error("interpolated value outside the table range");

endmodule

bind atmosphere_table_interpolator ati_checker u_ati_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .altitude_dm     (altitude_dm),
    .speed_cms       (speed_cms),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .temperature_ck  (temperature_ck),
    .pressure_pa     (pressure_pa),
    .density_e4      (density_e4),
    .sound_speed_cms (sound_speed_cms),
    .mach_q16        (mach_q16)
);

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int RANDOM_ITEMS  = 450;
    localparam int CALM_TAIL     = 60;
    localparam int HOLD_CYCLES   = 90;
    localparam int DRAIN_CYCLES  = 40;
    localparam int TIMEOUT_NS    = 4_000_000;
    localparam int TOP_ROW       = (ati_pkg::SEGMENTS_DEF > ati_pkg::ROM_LAST) ?
                                   ati_pkg::ROM_LAST :
                                   (ati_pkg::SEGMENTS_DEF < 1) ? 1 : ati_pkg::SEGMENTS_DEF;
    localparam longint MACH_SAT  = (64'd1 << ati_pkg::MACH_W) - 1;
    localparam int ALT_MIN       = -(1 << (ati_pkg::ALT_W - 1));
    localparam int ALT_MAX       = (1 << (ati_pkg::ALT_W - 1)) - 1;
    localparam int SPD_MAX       = (1 << ati_pkg::SPD_W) - 1;

    typedef struct packed {
        logic [ati_pkg::ALT_W-1:0] alt;
        logic [ati_pkg::SPD_W-1:0] spd;
    } sample_t;

    typedef struct packed {
        logic [ati_pkg::TEMP_W-1:0] temp;
        logic [ati_pkg::PRES_W-1:0] pres;
        logic [ati_pkg::DENS_W-1:0] dens;
        logic [ati_pkg::SND_W-1:0]  snd;
        logic [ati_pkg::MACH_W-1:0] mach;
    } air_data_t;

    // standard atmosphere rows, one every 5000 dm
    int temp_rows [0:12] = '{28815, 28490, 28165, 27840, 27515, 27190, 26865,
                             26540, 26215, 25890, 25565, 25240, 24915};
    int pres_rows [0:12] = '{101325, 95463, 89976, 84808, 79916, 75260, 70801,
                             66604, 62634, 58860, 55252, 51881, 48720};
    int dens_rows [0:12] = '{12250, 11673, 11117, 10581, 10066, 9570, 9093,
                             8635, 8196, 7775, 7369, 6979, 6605};
    int snd_rows  [0:12] = '{34029, 33837, 33644, 33450, 33254, 33057, 32858,
                             32658, 32456, 32252, 32047, 31840, 31631};

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [ati_pkg::ALT_W-1:0] altitude_dm = '0;
    logic [ati_pkg::SPD_W-1:0] speed_cms = '0;

    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [ati_pkg::TEMP_W-1:0] temperature_ck;
    logic [ati_pkg::PRES_W-1:0] pressure_pa;
    logic [ati_pkg::DENS_W-1:0] density_e4;
    logic [ati_pkg::SND_W-1:0]  sound_speed_cms;
    logic [ati_pkg::MACH_W-1:0] mach_q16;

    sample_t   sample_q [$];
    air_data_t air_q [$];
    sample_t   next_sample;
    air_data_t got_air;
    air_data_t want_air;

    int n_total = 0;
    int n_sent = 0;
    int n_errors = 0;
    int send_gap = 0;
    int stall_left = 0;
    int hold_left = 0;
    int holds_done = 0;

    atmosphere_table_interpolator DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .altitude_dm     (altitude_dm),
        .speed_cms       (speed_cms),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .temperature_ck  (temperature_ck),
        .pressure_pa     (pressure_pa),
        .density_e4      (density_e4),
        .sound_speed_cms (sound_speed_cms),
        .mach_q16        (mach_q16)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // value scaled by the step length at offset off into the segment
    function automatic longint seg_scaled(input int y0, input int y1, input int off);
        return longint'(y0) * ati_pkg::STEP_DM + longint'(y1 - y0) * off;
    endfunction

    function automatic longint round_step(input longint v);
        return (v + ati_pkg::HALF_STEP) / ati_pkg::STEP_DM;
    endfunction

    function automatic air_data_t atmo_predict(input logic signed [ati_pkg::ALT_W-1:0] alt,
                                               input logic [ati_pkg::SPD_W-1:0] spd);
        int        alt_i;
        int        row;
        int        nxt;
        int        off;
        longint    snd_scl;
        longint    quo;
        air_data_t r;
        alt_i = alt;
        if (alt_i <= 0)
        begin
            row = 0;
            off = 0;
        end
        else if (alt_i >= TOP_ROW * ati_pkg::STEP_DM)
        begin
            row = TOP_ROW;
            off = 0;
        end
        else
        begin
            row = alt_i / ati_pkg::STEP_DM;
            off = alt_i % ati_pkg::STEP_DM;
        end
        nxt = (row < ati_pkg::ROM_LAST) ? row + 1 : row;
        snd_scl = seg_scaled(snd_rows[row], snd_rows[nxt], off);
        r.temp = ati_pkg::TEMP_W'(round_step(seg_scaled(temp_rows[row], temp_rows[nxt], off)));
        r.pres = ati_pkg::PRES_W'(round_step(seg_scaled(pres_rows[row], pres_rows[nxt], off)));
        r.dens = ati_pkg::DENS_W'(round_step(seg_scaled(dens_rows[row], dens_rows[nxt], off)));
        r.snd  = ati_pkg::SND_W'(round_step(snd_scl));
        // Mach divides by the unrounded sound speed
        quo = (longint'(spd) * 65536 * ati_pkg::STEP_DM) / snd_scl;
        r.mach = ati_pkg::MACH_W'((quo > MACH_SAT) ? MACH_SAT : quo);
        return r;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d actual %0d", $realtime, name, want, got);
            n_errors++;
        end
    endtask

    task automatic add_sample(input int alt, input int spd);
        sample_t s;
        s.alt = ati_pkg::ALT_W'(alt);
        s.spd = ati_pkg::SPD_W'(spd);
        sample_q = {sample_q, s};
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                air_q = {air_q, atmo_predict(altitude_dm, speed_cms)};
                n_sent <= n_sent + 1;
            end
            // hold the word until it is taken
            if (!in_valid || in_ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (sample_q.size() != 0)
                begin
                    next_sample = sample_q.pop_front();
                    in_valid <= 1'b1;
                    altitude_dm <= next_sample.alt;
                    speed_cms <= next_sample.spd;
                    if (n_sent < n_total - CALM_TAIL && hold_left == 0
                        && $urandom_range(0, 7) == 0)
                        send_gap <= $urandom_range(1, 11);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off so the pipeline fills and in_ready drops
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            holds_done <= 0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if ((holds_done == 0 && n_sent >= 120) || (holds_done == 1 && n_sent >= 320))
        begin
            hold_left <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got_air.temp = temperature_ck;
                got_air.pres = pressure_pa;
                got_air.dens = density_e4;
                got_air.snd  = sound_speed_cms;
                got_air.mach = mach_q16;
                if (air_q.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none actual %h",
                             $realtime, got_air);
                    n_errors++;
                end
                else
                begin
                    want_air = air_q.pop_front();
                    check_field("temperature_ck", want_air.temp, got_air.temp);
                    check_field("pressure_pa", want_air.pres, got_air.pres);
                    check_field("density_e4", want_air.dens, got_air.dens);
                    check_field("sound_speed_cms", want_air.snd, got_air.snd);
                    check_field("mach_q16", want_air.mach, got_air.mach);
                end
            end
            if (hold_left != 0)
            begin
                out_ready <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                out_ready <= 1'b0;
            end
            else if (n_sent < n_total - CALM_TAIL && $urandom_range(0, 9) == 0)
            begin
                stall_left <= $urandom_range(1, 11) - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        int alt;
        int spd;
        int pick;

        // field extremes, breakpoints, half-way rounding, Mach saturation
        add_sample(ALT_MIN, 0);
        add_sample(-20000, 1);
        add_sample(-1, 100000);
        add_sample(0, SPD_MAX);
        add_sample(1, 0);
        add_sample(100, 50000);
        add_sample(2500, 34029);
        add_sample(4999, 1);
        add_sample(5000, 65535);
        add_sample(5001, 99999);
        add_sample(27500, 30000);
        add_sample(54999, 100000);
        add_sample(55000, 12345);
        add_sample(59999, SPD_MAX);
        add_sample(TOP_ROW * ati_pkg::STEP_DM, SPD_MAX);
        add_sample(TOP_ROW * ati_pkg::STEP_DM + 1, 70000);
        add_sample(200000, 100000);
        add_sample(131072, 65536);
        add_sample(ALT_MAX, SPD_MAX);
        add_sample(-131072, 86000);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                alt = $signed(ati_pkg::ALT_W'($urandom()));
            else if (pick <= 2)
                alt = $urandom_range(0, TOP_ROW + 1) * ati_pkg::STEP_DM
                      + $urandom_range(0, 4) - 2;
            else
                alt = $urandom_range(0, 220000) - 20000;
            pick = $urandom_range(0, 19);
            if (pick == 0)
                spd = 0;
            else if (pick <= 3)
                spd = $urandom_range(0, SPD_MAX);
            else
                spd = $urandom_range(0, 100000);
            add_sample(alt, spd);
        end
        n_total = sample_q.size();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (n_sent != n_total)
            @(posedge clk);
        while (air_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (n_errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
